// ===== design/ssrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrc_pkg
// Shared types and constants of the spike rate coder.
// ----------------------------------------------------------------------------
package ssrc_pkg;

    localparam int PERIOD_W  = 16;
    localparam int CHAN_W    = 4;
    localparam int VEL_W     = 16;
    localparam int NUM_VEL   = 3;
    localparam int BUMP_W    = 6;
    localparam int SLOPE_W   = 16;
    localparam int ICEPT_W   = 24;
    localparam int GROUND_W  = 24;
    localparam int MAG_W     = VEL_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [PERIOD_W-1:0] PERIOD_SAT = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] COUNT_INIT = 16'd1;

    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [MAG_W-1:0]    mag_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_SLOPE  = 3'd0,
        CFG_FREQ_ICEPT  = 3'd1,
        CFG_GROUND_FREQ = 3'd2,
        CFG_MAX_PERIOD  = 3'd3,
        CFG_BUMP_HIGH   = 3'd4,
        CFG_BUMP_LOW    = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_SENSOR = 1'b1
    } kind_t;

    // one cell's contents as it moves along the ring
    typedef struct packed {
        period_t period;
        period_t count;
    } cell_data_t;

endpackage

// ===== design/ssrc_if.sv =====
// ----------------------------------------------------------------------------
// ssrc_if
// Valid/ready channels for sensor items and spike results.
// ----------------------------------------------------------------------------
interface ssrc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [15:0]           wheel_vel_a;
    logic signed [15:0]           wheel_vel_b;
    logic signed [15:0]           wheel_vel_c;
    logic [5:0]                   bump_bits;

    modport source (output valid, kind, wheel_vel_a, wheel_vel_b, wheel_vel_c, bump_bits,
                    input ready);
    modport sink   (input valid, kind, wheel_vel_a, wheel_vel_b, wheel_vel_c, bump_bits,
                    output ready);
endinterface

interface ssrc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] channel;
    logic       last;

    modport source (output valid, channel, last, input ready);
    modport sink   (input valid, channel, last, output ready);
endinterface

// ===== design/ssrc_cell.sv =====
// ----------------------------------------------------------------------------
// ssrc_cell
// One ring cell: holds period and counter of one channel, passes them on.
// ----------------------------------------------------------------------------
module ssrc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  ssrc_pkg::cell_data_t d_in,
    output ssrc_pkg::cell_data_t d_out
);
    import ssrc_pkg::*;

    cell_data_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg.period <= PERIOD_SAT;
            data_reg.count  <= COUNT_INIT;
        end
        else if (shift)
        begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;

endmodule

// ===== design/ssrc_div.sv =====
// ----------------------------------------------------------------------------
// ssrc_div
// Wheel period unit: frequency by multiply-add, then restoring division.
// ----------------------------------------------------------------------------
module ssrc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  ssrc_pkg::mag_t                     mag,
    input  logic [ssrc_pkg::SLOPE_W-1:0]       slope,
    input  logic [ssrc_pkg::ICEPT_W-1:0]       intercept,
    input  logic [ssrc_pkg::GROUND_W-1:0]      ground,
    output logic                               done,
    output ssrc_pkg::period_t                  period
);
    import ssrc_pkg::*;

    localparam int F_W   = 34;
    localparam int REM_W = F_W + 1;
    localparam int DSH_W = REM_W + PERIOD_W;
    localparam int Q_W   = PERIOD_W + 1;
    localparam logic [4:0] LAST_STEP = 5'(Q_W - 1);

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_PREP, D_RUN} dstate_t;

    dstate_t            state_reg;
    mag_t               mag_reg;
    logic [F_W-1:0]     prod_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DSH_W-1:0]   dsh_reg;
    logic [Q_W-1:0]     q_reg;
    logic [4:0]         step_reg;
    logic               done_reg;

    logic [SLOPE_W+MAG_W-1:0] prod;
    logic [F_W-1:0]     freq;
    logic               ge;

    assign prod = slope * mag_reg;
    assign freq = prod_reg + F_W'(intercept);
    assign ge   = DSH_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg   <= mag;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL:
                begin
                    prod_reg  <= F_W'(prod);
                    state_reg <= D_PREP;
                end
                D_PREP:
                begin
                    // rounded: (2*g*256 + f) / (2*f)
                    rem_reg   <= (REM_W'(ground) << 9) + REM_W'(freq);
                    dsh_reg   <= DSH_W'({freq, 1'b0}) << PERIOD_W;
                    step_reg  <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    if (ge)
                        rem_reg <= rem_reg - REM_W'(dsh_reg);
                    q_reg   <= {q_reg[Q_W-2:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    if (step_reg == LAST_STEP)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    // top quotient bit set means the result exceeds 16 bits
    assign done   = done_reg;
    assign period = q_reg[Q_W-1] ? PERIOD_SAT : q_reg[PERIOD_W-1:0];

endmodule

// ===== design/sensor_spike_rate_coder.sv =====
// ----------------------------------------------------------------------------
// sensor_spike_rate_coder
// Sensor items set channel periods; tick items step a ring of channel cells.
// ----------------------------------------------------------------------------
// tick item: one ring step per channel, then a flush state that hands out any pending spike,
//   marked last; output stalls hold the ring
// sensor item: each wheel in turn through the shared period divider, then one ring turn
//   that loads the new periods into all channels
// one item at a time, input ready only in idle
// reset: all periods 65535, all counters 1, registers at their documented defaults
module sensor_spike_rate_coder #(
    parameter int NUM_WHEELS  = 3,
    parameter int NUM_BUMPERS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ssrc_in_if.sink                           sensor,
    ssrc_out_if.source                        spike,
    input  logic                              cfg_we,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssrc_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import ssrc_pkg::*;

    localparam int NUM_CH = 2 * NUM_WHEELS + NUM_BUMPERS;
    localparam int CW     = $clog2(NUM_CH);
    localparam int WW     = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam logic [CW-1:0] LAST_CH    = CW'(NUM_CH - 1);
    localparam logic [WW-1:0] LAST_WHEEL = WW'(NUM_WHEELS - 1);

    typedef enum logic [2:0] {S_IDLE, S_WHEEL, S_LOAD, S_TICK, S_FLUSH} state_t;

    // configuration
    logic [SLOPE_W-1:0]  slope_reg;
    logic [ICEPT_W-1:0]  icept_reg;
    logic [GROUND_W-1:0] ground_reg;
    period_t             maxp_reg;
    period_t             bhigh_reg;
    period_t             blow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg  <= 16'd256;
            icept_reg  <= 24'd256;
            ground_reg <= 24'd1000;
            maxp_reg   <= PERIOD_SAT;
            bhigh_reg  <= 16'd10;
            blow_reg   <= PERIOD_SAT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FREQ_SLOPE:  slope_reg  <= cfg_data[SLOPE_W-1:0];
                CFG_FREQ_ICEPT:  icept_reg  <= cfg_data[ICEPT_W-1:0];
                CFG_GROUND_FREQ: ground_reg <= cfg_data[GROUND_W-1:0];
                CFG_MAX_PERIOD:  maxp_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_BUMP_HIGH:   bhigh_reg  <= cfg_data[PERIOD_W-1:0];
                CFG_BUMP_LOW:    blow_reg   <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    state_t               state_reg;
    logic [CW-1:0]        k_reg;
    logic [WW-1:0]        w_reg;
    logic                 start_reg;
    logic                 pend_valid_reg;
    logic [CW-1:0]        pend_ch_reg;
    logic                 out_valid_reg;
    logic [CHAN_W-1:0]    out_ch_reg;
    logic                 out_last_reg;
    logic signed [VEL_W-1:0] vel_reg [NUM_VEL];
    logic [BUMP_W-1:0]    bump_reg;
    period_t              wp_reg [NUM_WHEELS];

    // ring
    cell_data_t           cell_q [NUM_CH];
    cell_data_t           tail;
    logic                 shift;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CH; gi++)
        begin : g_cell
            if (gi == NUM_CH - 1)
            begin : g_tail
                ssrc_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                  .d_in(tail), .d_out(cell_q[gi]));
            end
            else
            begin : g_mid
                ssrc_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                  .d_in(cell_q[gi+1]), .d_out(cell_q[gi]));
            end
        end
    endgenerate

    // wheel velocity select for the divider
    logic signed [VEL_W-1:0] div_vel;
    mag_t                    div_mag;
    logic                    div_done;
    period_t                 div_period;

    always_comb
    begin
        div_vel = '0;
        for (int w = 0; w < NUM_WHEELS; w++)
            if (WW'(w) == w_reg && w < NUM_VEL)
                div_vel = vel_reg[w % NUM_VEL];
        div_mag = div_vel[VEL_W-1] ? MAG_W'(-MAG_W'(div_vel)) : MAG_W'(div_vel);
    end

    ssrc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .mag(div_mag),
        .slope(slope_reg), .intercept(icept_reg), .ground(ground_reg),
        .done(div_done), .period(div_period)
    );

    // new period of the head channel during a load turn
    logic [NUM_BUMPERS-1:0] bump_ext;
    period_t                new_period;

    always_comb
    begin
        new_period = PERIOD_SAT;
        for (int j = 0; j < NUM_BUMPERS; j++)
            bump_ext[j] = (j < BUMP_W) ? bump_reg[j % BUMP_W] : 1'b0;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (CW'(2 * w) == k_reg || CW'(2 * w + 1) == k_reg)
            begin
                // period goes to the channel whose direction matches the sign
                if ((w < NUM_VEL) && vel_reg[w % NUM_VEL][VEL_W-1] == k_reg[0])
                    new_period = wp_reg[w];
                else if ((w >= NUM_VEL) && !k_reg[0])
                    new_period = wp_reg[w];
                else
                    new_period = maxp_reg;
            end
        end
        for (int j = 0; j < NUM_BUMPERS; j++)
            if (CW'(2 * NUM_WHEELS + j) == k_reg)
                new_period = bump_ext[j] ? bhigh_reg : blow_reg;
    end

    // tick logic on the head cell
    logic hit;
    logic out_free;
    logic stall;
    logic push_mid;
    logic push_fin;

    assign hit      = cell_q[0].count >= cell_q[0].period;
    assign out_free = !out_valid_reg || spike.ready;
    assign stall    = (state_reg == S_TICK) && hit && pend_valid_reg && !out_free;
    assign shift    = ((state_reg == S_LOAD) || (state_reg == S_TICK)) && !stall;
    assign push_mid = (state_reg == S_TICK) && hit && pend_valid_reg && out_free;
    assign push_fin = (state_reg == S_FLUSH) && pend_valid_reg && out_free;

    always_comb
    begin
        tail = cell_q[0];
        if (state_reg == S_LOAD)
            tail.period = new_period;
        else if (hit)
            tail.count = COUNT_INIT;
        else
            tail.count = cell_q[0].count + COUNT_INIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            w_reg          <= '0;
            start_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (spike.ready)
                out_valid_reg <= 1'b0;
            if (push_mid || push_fin)
            begin
                out_valid_reg <= 1'b1;
                out_ch_reg    <= CHAN_W'(pend_ch_reg);
                out_last_reg  <= push_fin;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg <= '0;
                    w_reg <= '0;
                    if (sensor.valid)
                    begin
                        vel_reg[0] <= sensor.wheel_vel_a;
                        vel_reg[1] <= sensor.wheel_vel_b;
                        vel_reg[2] <= sensor.wheel_vel_c;
                        bump_reg   <= sensor.bump_bits;
                        if (sensor.kind == KIND_SENSOR)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_WHEEL;
                        end
                        else
                            state_reg <= S_TICK;
                    end
                end
                S_WHEEL:
                begin
                    if (div_done)
                    begin
                        wp_reg[w_reg] <= div_period;
                        if (w_reg == LAST_WHEEL)
                            state_reg <= S_LOAD;
                        else
                        begin
                            w_reg     <= w_reg + WW'(1);
                            start_reg <= 1'b1;
                        end
                    end
                end
                S_LOAD:
                begin
                    k_reg <= k_reg + CW'(1);
                    if (k_reg == LAST_CH)
                        state_reg <= S_IDLE;
                end
                S_TICK:
                begin
                    if (!stall)
                    begin
                        if (hit)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_ch_reg    <= k_reg;
                        end
                        k_reg <= k_reg + CW'(1);
                        if (k_reg == LAST_CH)
                            state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                        state_reg <= S_IDLE;
                    else if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sensor.ready  = (state_reg == S_IDLE);
    assign spike.valid   = out_valid_reg;
    assign spike.channel = out_ch_reg;
    assign spike.last    = out_last_reg;

endmodule

// ===== design/ssrc_checker.sv =====
// ----------------------------------------------------------------------------
// ssrc_checker
// Port-level checks on the spike rate coder, bound to the top level.
// ----------------------------------------------------------------------------
module ssrc_checker #(
    parameter int NUM_CH = 12
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_channel,
    input logic       out_last
);

    // a stalled beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("spike beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_channel) && $stable(out_last))
        else $error("spike payload changed while stalled");

    // an accepted item closes the input, so no second item follows straight after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_channel) < NUM_CH || NUM_CH > 16)
        else $error("spike on nonexistent channel");

    // a new spike appears only while an item is in progress or as it ends
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready || $past(!in_ready))
        else $error("spike without a tick in progress");

endmodule

bind sensor_spike_rate_coder ssrc_checker #(.NUM_CH(2 * NUM_WHEELS + NUM_BUMPERS)) u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(sensor.valid),
    .in_ready(sensor.ready),
    .out_valid(spike.valid),
    .out_ready(spike.ready),
    .out_channel(spike.channel),
    .out_last(spike.last)
);
